// File: rtl/nss_pkg.sv
// shared types and constants for the nfa subset simulator
// no dependencies
package nss_pkg;

	localparam int MASK_W          = 32;
	localparam int STATE_W         = 5;
	localparam int SYM_W           = 2;
	localparam int OP_W            = 2;
	localparam int CFG_IDX_W       = 1;
	localparam int DEF_NUM_STATES  = 32;
	localparam int DEF_NUM_SYMBOLS = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} nss_op_t;

	typedef struct packed {
		logic               wr;
		logic               step;
		logic [STATE_W-1:0] src;
		logic [SYM_W-1:0]   sym;
		logic [MASK_W-1:0]  row;
	} nss_req_t;

	typedef struct packed {
		logic ready;
		logic done;
	} nss_rsp_t;

endpackage

// File: rtl/nfa_subset_simulator.sv
// Runs a nondeterministic automaton of NUM_STATES states (at most 32 are reachable through the
// 32-bit masks) over NUM_SYMBOLS symbols. Row writes, start and the unused opcode mark their
// result pending when taken; a consume item first scans the transition table one row per state
// through its single-port memory (no scan for a symbol out of range, giving the empty set).
// After reset the table memory, 2**(clog2(min(states,32))+clog2(symbols)) words (128 at the
// defaults), is swept to zero with in_ready low; configuration writes are always taken.
// One finished result may wait in the output register while the next item is taken.
// depends on nss_pkg and nss_step_unit
module nfa_subset_simulator
	import nss_pkg::*;
#(
	parameter int NUM_STATES  = DEF_NUM_STATES,
	parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MASK_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [STATE_W-1:0]   source_state,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [MASK_W-1:0]    next_mask,
	input  logic [STATE_W-1:0]   query_state,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MASK_W-1:0]    active_mask,
	output logic                 accepted,
	output logic                 query_reached,
	output logic                 any_active
);

	localparam int MW = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;

	logic [MASK_W-1:0]  initial_q;
	logic [MASK_W-1:0]  final_q;
	logic [MW-1:0]      active_q;
	logic [STATE_W-1:0] query_q;
	logic               busy_q;
	logic               pend_q;
	logic               out_valid_q;
	logic [MASK_W-1:0]  active_mask_q;
	logic               accepted_q;
	logic               query_reached_q;
	logic               any_active_q;

	nss_req_t           req;
	nss_rsp_t           rsp;
	logic [MW-1:0]      next_set;
	logic               in_acc;
	logic               load_out;
	nss_op_t            op;
	logic [MASK_W-1:0]  act_ext;

	assign op        = nss_op_t'(opcode);
	assign cfg_ready = 1'b1;
	assign in_ready  = rsp.ready && !busy_q && !pend_q;
	assign in_acc    = in_valid && in_ready;
	assign load_out  = pend_q && (!out_valid_q || out_ready);
	assign act_ext   = MASK_W'(active_q);

	assign req.wr   = in_acc && (op == OP_WRITE);
	assign req.step = in_acc && (op == OP_STEP);
	assign req.src  = source_state;
	assign req.sym  = symbol;
	assign req.row  = next_mask;

	nss_step_unit #(
		.MW         (MW),
		.NUM_STATES (NUM_STATES),
		.NUM_SYMBOLS(NUM_SYMBOLS)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cur_set (active_q),
		.rsp     (rsp),
		.next_set(next_set)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= '0;
			final_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INITIAL: initial_q <= cfg_data;
				CFG_FINAL:   final_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				case (op)
					OP_STEP: begin
						busy_q <= 1'b1;
					end
					OP_START: begin
						active_q <= initial_q[MW-1:0];
						pend_q   <= 1'b1;
					end
					default: begin
						pend_q <= 1'b1;
					end
				endcase
			end
			if (rsp.done) begin
				active_q <= next_set;
				busy_q   <= 1'b0;
				pend_q   <= 1'b1;
			end
			if (load_out) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			query_q <= query_state;
		end
		if (load_out) begin
			active_mask_q   <= act_ext;
			accepted_q      <= |(active_q & final_q[MW-1:0]);
			query_reached_q <= (32'(query_q) < NUM_STATES) && act_ext[query_q];
			any_active_q    <= |active_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign active_mask   = active_mask_q;
	assign accepted      = accepted_q;
	assign query_reached = query_reached_q;
	assign any_active    = any_active_q;

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> busy_q)
		else $error("step unit finished with no consume item in flight");

	a_busy_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && pend_q))
		else $error("result pending while a consume item is still running");

	a_done_to_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> pend_q)
		else $error("finished consume item lost its result");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !rsp.done |=> !in_acc)
		else $error("item taken while a consume item is running");

endmodule

// File: rtl/nss_ram.sv
// generic single-port ram with registered read
// no dependencies
module nss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/nss_step_unit.sv
// transition table and row scan sequencer: clears the table after reset,
// writes rows, and ors the rows of active states into the next set
// depends on nss_pkg and nss_ram
module nss_step_unit
	import nss_pkg::*;
#(
	parameter int MW          = 32,
	parameter int NUM_STATES  = DEF_NUM_STATES,
	parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nss_req_t      req,
	input  logic [MW-1:0] cur_set,
	output nss_rsp_t      rsp,
	output logic [MW-1:0] next_set
);

	localparam int QW    = $clog2(MW);
	localparam int SYW   = $clog2(NUM_SYMBOLS);
	localparam int AW    = QW + SYW;
	localparam int DEPTH = 2 ** AW;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_LAST  = 4'b1000
	} nss_state_t;

	nss_state_t      st_q;
	logic [AW-1:0]   clr_q;
	logic [QW-1:0]   q_q;
	logic [SYW-1:0]  sym_q;
	logic [MW-1:0]   acc_q;
	logic            rd_s1;

	logic            src_ok;
	logic            sym_ok;
	logic            wr_ok;
	logic            ram_en;
	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [MW-1:0]   ram_wdata;
	logic [MW-1:0]   ram_rdata;

	assign src_ok = 32'(req.src) < NUM_STATES;
	assign sym_ok = 32'(req.sym) < NUM_SYMBOLS;
	assign wr_ok  = (st_q == ST_IDLE) && req.wr && src_ok && sym_ok;

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = {QW'(req.src), SYW'(req.sym)};
		ram_wdata = req.row[MW-1:0];
		case (st_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_SCAN: begin
				ram_en   = 1'b1;
				ram_addr = {q_q, sym_q};
			end
			ST_IDLE: begin
				ram_en = wr_ok;
				ram_we = wr_ok;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	nss_ram #(
		.WIDTH(MW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
			q_q   <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (st_q == ST_SCAN) && cur_set[q_q];
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					q_q <= '0;
					if (req.step) begin
						st_q <= sym_ok ? ST_SCAN : ST_LAST;
					end
				end
				ST_SCAN: begin
					q_q <= q_q + 1'b1;
					if (q_q == QW'(MW - 1)) begin
						st_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			sym_q <= SYW'(req.sym);
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q | ram_rdata;
		end
	end

	assign rsp.ready = (st_q == ST_IDLE);
	assign rsp.done  = (st_q == ST_LAST);
	assign next_set  = acc_q | (rd_s1 ? ram_rdata : '0);

endmodule

// File: dv/tb.sv
// testbench for nfa_subset_simulator: a directed table then random automata and symbol strings,
// every result checked against a fixed expectation or an in-bench model of the active state set
// depends on nss_pkg and the rtl of nfa_subset_simulator
`timescale 1ns / 100ps

module tb;
	import nss_pkg::*;

	localparam int NST        = DEF_NUM_STATES;
	localparam int NSYM       = DEF_NUM_SYMBOLS;
	localparam int QUIET_MAX  = 3000;
	localparam int RAND_ITEMS = 450;
	localparam int CFG_EVERY  = 75;
	localparam logic [MASK_W-1:0] STATE_BITS =
		(NST >= MASK_W) ? '1 : MASK_W'((64'd1 << NST) - 64'd1);

	typedef struct packed {
		logic [MASK_W-1:0] set;
		logic              acc;
		logic              hit;
		logic              live;
	} nfa_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} plan_kind_t;

	typedef struct {
		plan_kind_t           kind;
		nss_op_t              op;
		logic [STATE_W-1:0]   src;
		logic [SYM_W-1:0]     sym;
		logic [MASK_W-1:0]    mask;
		logic [STATE_W-1:0]   qry;
		logic [CFG_IDX_W-1:0] idx;
		bit                   typed;
		nfa_result_t          want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MASK_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode = '0;
	logic [STATE_W-1:0]   source_state = '0;
	logic [SYM_W-1:0]     symbol = '0;
	logic [MASK_W-1:0]    next_mask = '0;
	logic [STATE_W-1:0]   query_state = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [MASK_W-1:0]    active_mask;
	logic                 accepted;
	logic                 query_reached;
	logic                 any_active;

	logic [MASK_W-1:0] trans_rows [NST*NSYM];
	logic [MASK_W-1:0] cur_set = '0;
	logic [MASK_W-1:0] init_reg = '0;
	logic [MASK_W-1:0] final_reg = '0;
	nfa_result_t       pending_reports[$];
	plan_row_t         plan[$];
	int                errors = 0;
	int                quiet = 0;
	int                send_idle_pct = 33;
	int                recv_idle_pct = 50;

	nfa_subset_simulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.source_state (source_state),
		.symbol       (symbol),
		.next_mask    (next_mask),
		.query_state  (query_state),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.active_mask  (active_mask),
		.accepted     (accepted),
		.query_reached(query_reached),
		.any_active   (any_active)
	);

	always #1 clk = ~clk;

	function automatic nfa_result_t advance_nfa(input nss_op_t op, input logic [STATE_W-1:0] src,
			input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] nmask,
			input logic [STATE_W-1:0] qry);
		nfa_result_t      res;
		logic [MASK_W-1:0] nxt;
		nxt = '0;
		case (op)
			OP_WRITE: begin
				if (src < NST && sym < NSYM)
					trans_rows[src*NSYM + sym] = nmask & STATE_BITS;
			end
			OP_START: cur_set = init_reg & STATE_BITS;
			OP_STEP: begin
				if (sym < NSYM)
					for (int q = 0; q < NST && q < MASK_W; q++)
						if (cur_set[q])
							nxt |= trans_rows[q*NSYM + sym];
				cur_set = nxt & STATE_BITS;
			end
			default: ;
		endcase
		res.set  = cur_set;
		res.acc  = |(cur_set & final_reg);
		res.hit  = (qry < NST) && cur_set[qry];
		res.live = |cur_set;
		return res;
	endfunction

	function automatic logic [MASK_W-1:0] rand_mask();
		logic [MASK_W-1:0] m;
		m = '0;
		case ($urandom_range(9))
			0: m = '0;
			1: m = '1;
			2, 3: m = $urandom;
			default: begin
				for (int b = $urandom_range(2); b >= 0; b--)
					m[STATE_W'($urandom_range(MASK_W-1))] = 1'b1;
			end
		endcase
		return m;
	endfunction

	function automatic plan_row_t item_row(input nss_op_t op, input logic [STATE_W-1:0] src,
			input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] mask,
			input logic [STATE_W-1:0] qry, input bit typed, input nfa_result_t want);
		plan_row_t r;
		r.kind  = ROW_ITEM;
		r.op    = op;
		r.src   = src;
		r.sym   = sym;
		r.mask  = mask;
		r.qry   = qry;
		r.idx   = '0;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [MASK_W-1:0] data);
		plan_row_t r;
		r = item_row(OP_NONE, '0, '0, data, '0, 1'b0, '0);
		r.kind = ROW_CFG;
		r.idx  = idx;
		return r;
	endfunction

	task automatic send_item(input nss_op_t op, input logic [STATE_W-1:0] src,
			input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] nmask,
			input logic [STATE_W-1:0] qry, input bit typed, input nfa_result_t want);
		nfa_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		source_state <= src;
		symbol       <= sym;
		next_mask    <= nmask;
		query_state  <= qry;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = advance_nfa(op, src, sym, nmask, qry);
		pending_reports.push_back(typed ? want : res);
	endtask

	task automatic drain_items();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_INITIAL)
			init_reg = data;
		else
			final_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_result
		nfa_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected item, active_mask %h", $time, active_mask);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (want.set !== active_mask) begin
					$display("%0t: active_mask expected %h got %h", $time, want.set, active_mask);
					errors++;
				end
				if (want.acc !== accepted) begin
					$display("%0t: accepted expected %b got %b", $time, want.acc, accepted);
					errors++;
				end
				if (want.hit !== query_reached) begin
					$display("%0t: query_reached expected %b got %b", $time, want.hit,
						query_reached);
					errors++;
				end
				if (want.live !== any_active) begin
					$display("%0t: any_active expected %b got %b", $time, want.live, any_active);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_MAX) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		nss_op_t          op;
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] qry;
		logic [SYM_W-1:0]   sym;
		logic [MASK_W-1:0]  nmask;
		int                 r;

		foreach (trans_rows[i])
			trans_rows[i] = '0;

		// reset config: nothing is initial, nothing is accepting
		plan.push_back(item_row(OP_NONE, 5'd0, 2'd0, '0, 5'd0, 1'b1,
			{32'h0, 1'b0, 1'b0, 1'b0}));
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd3, '1, 5'd31, 1'b1,
			{32'h0, 1'b0, 1'b0, 1'b0}));
		plan.push_back(item_row(OP_START, 5'd31, 2'd3, '0, 5'd0, 1'b1,
			{32'h0, 1'b0, 1'b0, 1'b0}));
		plan.push_back(cfg_row(CFG_INITIAL, 32'hffff_ffff));
		plan.push_back(cfg_row(CFG_FINAL, 32'h8000_0000));
		plan.push_back(item_row(OP_START, 5'd0, 2'd0, '0, 5'd31, 1'b1,
			{32'hffff_ffff, 1'b1, 1'b1, 1'b1}));
		// table is clear after reset, so every state dies
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd0, '0, 5'd0, 1'b1,
			{32'h0, 1'b0, 1'b0, 1'b0}));
		plan.push_back(item_row(OP_START, 5'd0, 2'd0, '0, 5'd7, 1'b1,
			{32'hffff_ffff, 1'b1, 1'b1, 1'b1}));
		// row writes leave the active set alone
		plan.push_back(item_row(OP_WRITE, 5'd0, 2'd0, 32'hffff_ffff, 5'd0, 1'b1,
			{32'hffff_ffff, 1'b1, 1'b1, 1'b1}));
		plan.push_back(item_row(OP_WRITE, 5'd31, 2'd3, 32'h8000_0000, 5'd31, 1'b0, '0));
		plan.push_back(item_row(OP_WRITE, 5'd31, 2'd1, 32'h0000_0001, 5'd0, 1'b0, '0));
		plan.push_back(cfg_row(CFG_INITIAL, 32'h0000_0001));
		plan.push_back(item_row(OP_START, 5'd0, 2'd0, '0, 5'd0, 1'b1,
			{32'h0000_0001, 1'b0, 1'b1, 1'b1}));
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd0, '0, 5'd31, 1'b0, '0));
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd3, '0, 5'd31, 1'b0, '0));
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd1, '0, 5'd0, 1'b0, '0));
		plan.push_back(item_row(OP_WRITE, 5'd10, 2'd2, '0, 5'd10, 1'b0, '0));
		plan.push_back(item_row(OP_NONE, 5'd31, 2'd3, '1, 5'd31, 1'b0, '0));
		plan.push_back(cfg_row(CFG_FINAL, 32'hffff_ffff));
		plan.push_back(item_row(OP_NONE, 5'd0, 2'd0, '0, 5'd0, 1'b0, '0));
		plan.push_back(item_row(OP_STEP, 5'd0, 2'd2, '0, 5'd0, 1'b0, '0));
		plan.push_back(cfg_row(CFG_INITIAL, 32'h0));
		plan.push_back(cfg_row(CFG_FINAL, 32'h0));
		plan.push_back(item_row(OP_START, 5'd0, 2'd0, '0, 5'd0, 1'b1,
			{32'h0, 1'b0, 1'b0, 1'b0}));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_items();
				write_reg(plan[i].idx, plan[i].mask);
			end else begin
				send_item(plan[i].op, plan[i].src, plan[i].sym, plan[i].mask, plan[i].qry,
					plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 50 : 0;
			recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 33 : 0;
			for (int k = 0; k < RAND_ITEMS; k++) begin
				if (k % CFG_EVERY == 0) begin
					drain_items();
					write_reg(CFG_INITIAL, rand_mask());
					write_reg(CFG_FINAL, rand_mask());
				end
				r     = $urandom_range(99);
				op    = (r < 18) ? OP_WRITE : (r < 28) ? OP_START : (r < 95) ? OP_STEP : OP_NONE;
				src   = STATE_W'($urandom_range(NST-1));
				sym   = SYM_W'($urandom_range(3));
				nmask = rand_mask();
				qry   = STATE_W'($urandom_range(31));
				// when some state is live, half the queries aim at a state that is live now
				if (cur_set != 0 && $urandom_range(1))
					while (!cur_set[qry])
						qry = STATE_W'($urandom_range(31));
				send_item(op, src, sym, nmask, qry, 1'b0, '0);
			end
		end

		drain_items();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_reports.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/nss_pkg.sv
rtl/nss_ram.sv
rtl/nss_step_unit.sv
rtl/nfa_subset_simulator.sv
dv/tb.sv
